FILE: hw/rtl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// Depends on nothing; imported by the stack top level and its testbench.
package mts_pkg;

    localparam int unsigned DATA_W = 32;

    // Value reported for top and minimum when the stack holds nothing.
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // Request codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
    } rsp_t;

endpackage

FILE: hw/rtl/mts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for both stores of the min-tracking stack.
module mts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/min_tracking_stack_top.sv
// Min-tracking stack top level: value and minimum stores, cached top/min, result register.
// Depends on mts_pkg and mts_ram.
//
// A stack of signed 32-bit words that reports its top and its smallest element after
// every request. A push, a refused push (full) or a refused pop (empty) produces its
// result word in the cycle after acceptance; a pop that removes an element first passes
// through the fetch state, as the new top and minimum come from the registered read port
// of the value and minimum memories. A request is taken in the idle state once the result
// register is free or being drained in the same cycle, so a pop holds off the next request
// until its result is registered; pushes run at one word per cycle while m_ready holds. The
// memories need no clearing after reset; the element counts alone decide what is valid.
module min_tracking_stack_top #(
    parameter int unsigned STACK_DEPTH = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mts_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mts_pkg::rsp_t m_data
);

    import mts_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t                   state_reg,  state_next;
    logic [CW-1:0]            vcnt_reg,   vcnt_next;
    logic [CW-1:0]            mcnt_reg,   mcnt_next;
    logic signed [DATA_W-1:0] top_reg,    top_next;
    logic signed [DATA_W-1:0] min_reg,    min_next;
    logic                     m_valid_reg, m_valid_next;
    rsp_t                     m_data_reg, m_data_next;

    logic                     v_we, m_we, rd_en;
    logic [AW-1:0]            v_waddr, m_waddr, v_raddr, m_raddr;
    logic [DATA_W-1:0]        v_rdata, m_rdata;
    logic [CW-1:0]            v_rd_cnt, m_rd_cnt;
    logic signed [DATA_W-1:0] push_val;
    logic                     accept;
    logic                     is_full;

    assign push_val = s_data.push_value;
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (vcnt_reg == CW'(STACK_DEPTH));

    // Read addresses for a pop: new top sits two below the old count, new minimum one
    // below the updated minimum count.
    assign v_rd_cnt = vcnt_reg - CW'(2);
    assign m_rd_cnt = mcnt_next - CW'(1);
    assign v_raddr  = v_rd_cnt[AW-1:0];
    assign m_raddr  = m_rd_cnt[AW-1:0];
    assign v_waddr  = vcnt_reg[AW-1:0];
    assign m_waddr  = mcnt_reg[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        vcnt_next    = vcnt_reg;
        mcnt_next    = mcnt_reg;
        top_next     = top_reg;
        min_next     = min_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        v_we         = 1'b0;
        m_we         = 1'b0;
        rd_en        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == OP_PUSH) begin
                        m_valid_next = 1'b1;
                        if (is_full) begin
                            m_data_next = '{STAT_FULL, top_reg, min_reg, 1'b0};
                        end else begin
                            v_we      = 1'b1;
                            vcnt_next = vcnt_reg + CW'(1);
                            top_next  = push_val;
                            if (mcnt_reg == '0 || push_val <= min_reg) begin
                                m_we      = 1'b1;
                                mcnt_next = mcnt_reg + CW'(1);
                                min_next  = push_val;
                            end
                            m_data_next = '{STAT_DONE, push_val, min_next, 1'b0};
                        end
                    end else begin
                        if (vcnt_reg == '0) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{STAT_EMPTY, INT_MAX, INT_MAX, 1'b1};
                        end else begin
                            vcnt_next = vcnt_reg - CW'(1);
                            if (mcnt_reg != '0 && top_reg == min_reg) begin
                                mcnt_next = mcnt_reg - CW'(1);
                            end
                            rd_en      = 1'b1;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                top_next     = (vcnt_reg == '0) ? INT_MAX : signed'(v_rdata);
                min_next     = (mcnt_reg == '0) ? INT_MAX : signed'(m_rdata);
                m_valid_next = 1'b1;
                m_data_next  = '{STAT_DONE, top_next, min_next, vcnt_reg == '0};
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcnt_reg    <= '0;
            mcnt_reg    <= '0;
            top_reg     <= INT_MAX;
            min_reg     <= INT_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vcnt_reg    <= vcnt_next;
            mcnt_reg    <= mcnt_next;
            top_reg     <= top_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (push_val),
        .re    (rd_en),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .aclk  (aclk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (push_val),
        .re    (rd_en),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // The minimum stack never holds more entries than the value stack.
    a_mcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mcnt_reg <= vcnt_reg)
        else $error("minimum count exceeds value count");

    // Both stacks are empty together.
    a_empty_together: assert property (@(posedge aclk) disable iff (!aresetn)
        (vcnt_reg == '0) == (mcnt_reg == '0))
        else $error("value and minimum stacks disagree on emptiness");

    // A pop that removes an element enters the fetch state, then presents its result.
    a_pop_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == OP_POP && vcnt_reg != '0)
        |=> (state_reg == ST_FETCH) ##1 m_valid_reg)
        else $error("pop result not presented after fetch");

    // An accepted push into a non-full stack becomes the cached top.
    a_push_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == OP_PUSH && !is_full)
        |=> (top_reg == $past(push_val)) && (min_reg <= top_reg))
        else $error("pushed word not cached as top");

endmodule

FILE: tb/sv/min_tracking_stack_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_tracking_stack_top: a short directed script, then random
// push/pop traffic with random idling on both sides, checked word by word by a stack predictor.
// Depends on mts_pkg and the min_tracking_stack_top RTL.
module min_tracking_stack_top_tb;
    import mts_pkg::*;

    localparam int unsigned STACK_DEPTH    = 128;
    localparam int          RANDOM_WORDS   = 1680;
    localparam int          HOLD_AT        = 500;
    localparam int          PAUSE_AT       = 1000;
    localparam int          QUIET_AT       = 1480;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;

    typedef enum {FILL_UP, DRAIN, CHURN} mix_t;

    typedef struct {
        req_t req;
        bit   fixed;
        rsp_t rsp;
    } script_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // Predictor state: value stack, minimum stack and their fill counts.
    logic signed [DATA_W-1:0] value_stack [STACK_DEPTH];
    logic signed [DATA_W-1:0] low_stack   [STACK_DEPTH];
    int unsigned value_cnt = 0;
    int unsigned min_cnt   = 0;

    rsp_t        expected_rsp [$];
    script_row_t script [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int push_words   = 0;
    int pop_words    = 0;
    int full_refused = 0;
    int empty_refused = 0;
    int deepest      = 0;
    bit gaps_on      = 1'b1;
    bit rx_stalls    = 1'b1;
    bit long_hold    = 1'b0;

    min_tracking_stack_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one request to the predicted stack and returns the word it should produce.
    function automatic rsp_t stack_apply(req_t req);
        rsp_t                     r;
        logic signed [DATA_W-1:0] removed;
        r.status = STAT_DONE;
        if (req.req_type == OP_PUSH) begin
            if (value_cnt >= STACK_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                value_stack[value_cnt] = req.push_value;
                value_cnt++;
                // Ties go onto the minimum stack again, so each equal pop drops one copy.
                if (min_cnt == 0 || req.push_value <= low_stack[min_cnt-1]) begin
                    if (min_cnt < STACK_DEPTH) begin
                        low_stack[min_cnt] = req.push_value;
                        min_cnt++;
                    end
                end
            end
        end else if (value_cnt == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            removed = value_stack[value_cnt-1];
            value_cnt--;
            if (min_cnt != 0 && removed == low_stack[min_cnt-1])
                min_cnt--;
        end
        r.top_value = (value_cnt == 0) ? INT_MAX : value_stack[value_cnt-1];
        r.min_value = (min_cnt == 0) ? INT_MAX : low_stack[min_cnt-1];
        r.is_empty  = (value_cnt == 0);
        return r;
    endfunction

    // Small values are favored so that equal minimums come up often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return MOST_NEGATIVE;
            1:       return INT_MAX;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic op, logic signed [DATA_W-1:0] value, bit fixed,
                           logic [1:0] st, logic signed [DATA_W-1:0] top,
                           logic signed [DATA_W-1:0] low, logic none_left);
        script_row_t row;
        row.req.req_type   = op;
        row.req.push_value = value;
        row.fixed          = fixed;
        row.rsp.status     = st;
        row.rsp.top_value  = top;
        row.rsp.min_value  = low;
        row.rsp.is_empty   = none_left;
        script.push_back(row);
    endtask

    task automatic send_word(req_t req, bit fixed, rsp_t fixed_rsp);
        rsp_t predicted;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = stack_apply(req);
        expected_rsp.push_back(fixed ? fixed_rsp : predicted);
        if (req.req_type == OP_PUSH) push_words++;
        else pop_words++;
        if (predicted.status == STAT_FULL) full_refused++;
        if (predicted.status == STAT_EMPTY) empty_refused++;
        if (value_cnt > deepest) deepest = value_cnt;
    endtask

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t ns: unexpected result word, status %0d top %0d min %0d empty %0d",
                         $time, m_data.status, m_data.top_value, m_data.min_value,
                         m_data.is_empty);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                check_field("status", int'(want.status), int'(m_data.status));
                check_field("top_value", int'(want.top_value), int'(m_data.top_value));
                check_field("min_value", int'(want.min_value), int'(m_data.min_value));
                check_field("is_empty", int'(want.is_empty), int'(m_data.is_empty));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("min_tracking_stack_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold that stalls the request side.
    initial begin
        wait (aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        mix_t mix;
        int   run_left;
        int   push_pct;
        req_t req;

        add_row(OP_POP,  0,             1, STAT_EMPTY, INT_MAX,       INT_MAX,       1'b1);
        add_row(OP_PUSH, INT_MAX,       1, STAT_DONE,  INT_MAX,       INT_MAX,       1'b0);
        add_row(OP_POP,  0,             1, STAT_DONE,  INT_MAX,       INT_MAX,       1'b1);
        add_row(OP_POP,  -1,            1, STAT_EMPTY, INT_MAX,       INT_MAX,       1'b1);
        add_row(OP_PUSH, MOST_NEGATIVE, 1, STAT_DONE,  MOST_NEGATIVE, MOST_NEGATIVE, 1'b0);
        add_row(OP_PUSH, INT_MAX,       1, STAT_DONE,  INT_MAX,       MOST_NEGATIVE, 1'b0);
        add_row(OP_PUSH, MOST_NEGATIVE, 1, STAT_DONE,  MOST_NEGATIVE, MOST_NEGATIVE, 1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             1, STAT_DONE,  INT_MAX,       INT_MAX,       1'b1);
        add_row(OP_PUSH, 5,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_PUSH, 3,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_PUSH, 3,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_PUSH, 7,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_PUSH, -1,            0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_POP,  0,             0, STAT_DONE,  0,             0,             1'b0);
        add_row(OP_PUSH, 32'sh5555_5555, 0, STAT_DONE, 0,             0,             1'b0);
        add_row(OP_POP,  32'shAAAA_AAAA, 0, STAT_DONE, 0,             0,             1'b0);
        add_row(OP_POP,  0,             1, STAT_DONE,  INT_MAX,       INT_MAX,       1'b1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i])
            send_word(script[i].req, script[i].fixed, script[i].rsp);

        run_left = 0;
        mix      = CHURN;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (expected_rsp.size() != 0) @(posedge aclk);
            end
            // The first two runs fill the stack past full and then drain it past empty.
            if (n == 0 || n == 190) begin
                mix      = (n == 0) ? FILL_UP : DRAIN;
                run_left = 190;
            end else if (n == HOLD_AT) begin
                long_hold = 1'b1;
                gaps_on   = 1'b0;
                mix       = FILL_UP;
                run_left  = 120;
            end else if (n == QUIET_AT) begin
                gaps_on   = 1'b0;
                rx_stalls = 1'b0;
                mix       = CHURN;
                run_left  = RANDOM_WORDS;
            end else if (run_left == 0) begin
                mix       = mix_t'($urandom_range(0, 2));
                run_left  = $urandom_range(40, 200);
                gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            run_left--;

            case (mix)
                FILL_UP: push_pct = 90;
                DRAIN:   push_pct = 10;
                default: push_pct = 50;
            endcase
            req.req_type   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            req.push_value = pick_value();
            send_word(req, 1'b0, '0);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d pushes and %0d pops; %0d pushes refused as full, %0d pops refused",
                 push_words, pop_words, full_refused, empty_refused);
        $display("as empty; deepest stack reached %0d of %0d entries.", deepest, STACK_DEPTH);
        if (errors == 0) begin
            $display("min_tracking_stack_top: match");
        end else begin
            $display("min_tracking_stack_top: mismatch");
        end
        $finish;
    end

endmodule
